// ===== src/rffba_pkg.sv =====
// shared types and constants of the refcounted first-fit block allocator
package rffba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int AGENT_BITS = 8;
  localparam int FIELD_W    = 11;
  localparam int SIZE_W     = 32;
  localparam int BB_W       = 17;
  localparam int REFS_W     = 8;
  localparam int USED_MAX   = 2047;

  localparam logic [AGENT_BITS-1:0] NO_OWNER = '1;
  localparam logic [REFS_W-1:0]     REFS_MAX = '1;

  typedef enum logic [1:0] {
    BLK_FREE   = 2'd0,
    BLK_ALLOC  = 2'd1,
    BLK_SHARED = 2'd2
  } blk_state_t;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_SHARE   = 2'd2,
    REQ_UNSHARE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_RANGE_ERR = 2'd2
  } stat_t;

  typedef enum logic {
    CFG_BLOCK_BYTES   = 1'b0,
    CFG_BLOCKS_IN_USE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    blk_state_t            st;
    logic [REFS_W-1:0]     refs;
    logic [AGENT_BITS-1:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // divider handshake toward the top level
  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
    logic              rem_nz;
  } div_res_t;

endpackage

// ===== src/rffba_ram.sv =====
// generic simple dual-port ram with registered read
module rffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rffba_div.sv =====
// restoring divider, one quotient bit per cycle
module rffba_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rffba_pkg::SIZE_W-1:0]   dividend,
  input  logic [rffba_pkg::BB_W-1:0]     divisor,
  output rffba_pkg::div_res_t            res
);

  localparam int STEP_W = $clog2(rffba_pkg::SIZE_W + 1);

  logic                         busy;
  logic                         done;
  logic [STEP_W-1:0]            step;
  logic [rffba_pkg::SIZE_W-1:0] quot;
  logic [rffba_pkg::BB_W-1:0]   dvs;
  logic [rffba_pkg::BB_W-1:0]   rem;
  logic [rffba_pkg::BB_W:0]     trial;
  logic                         fits;

  assign trial = {rem, quot[rffba_pkg::SIZE_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quot <= dividend;
        rem  <= '0;
        // a zero block size acts as one
        dvs  <= (divisor == '0) ? rffba_pkg::BB_W'(1) : divisor;
      end else if (busy) begin
        rem  <= fits ? rffba_pkg::BB_W'(trial - {1'b0, dvs}) : trial[rffba_pkg::BB_W-1:0];
        quot <= {quot[rffba_pkg::SIZE_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(rffba_pkg::SIZE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = '{done: done, quot: quot, rem_nz: (rem != '0)};

endmodule

// ===== src/refcounted_first_fit_block_allocator.sv =====
// top level of the refcounted first-fit block allocator
// operation: allocate divides the size by the block size, then scans for a free run and
//   writes each granted block; free, share and unshare walk their range entry by entry
// throughput: one request at a time, with all table work going through the single
//   table memory, which is read and written through its two ports
// reset: synchronous; after it a clearing pass writes every table entry
//   to free, no references, no owner while s_tready stays low
module refcounted_first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // agent, size_bytes, range_start, range_count, zero pad
  input  logic [1:0]  s_tuser,   // req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, start_block, granted_count, used_total, zero pad
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int IW = rffba_pkg::IDX_W;
  localparam int FW = rffba_pkg::FIELD_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN, S_FILL, S_WALK, S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [rffba_pkg::BB_W-1:0] block_bytes;
  logic [FW-1:0]              blocks_in_use;
  logic [FW-1:0]              m;

  // request held for the whole walk
  rffba_pkg::req_t                  req;
  logic [rffba_pkg::AGENT_BITS-1:0] agent;
  logic [FW-1:0]                    rstart;
  logic [FW-1:0]                    rcount;

  // walk and scan bookkeeping
  logic [FW-1:0] cnt;      // scan address, walk offset, fill offset, clear address
  logic [FW-1:0] run;      // free blocks seen in a row
  logic [FW-1:0] need;     // blocks asked for
  logic [IW-1:0] start0;   // zero-based first granted block
  logic          p_valid;  // read data in flight for p_idx
  logic [IW-1:0] p_idx;
  logic          err;

  // result
  rffba_pkg::stat_t status;
  logic [FW-1:0]    start_block;
  logic [FW-1:0]    granted;
  logic [FW-1:0]    used;

  rffba_pkg::div_res_t div_res;
  logic                div_start;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  rffba_pkg::entry_t      ram_wdata;
  logic [IW-1:0]          ram_raddr;
  rffba_pkg::entry_t      ram_rdata;
  logic [rffba_pkg::ENTRY_W-1:0] ram_rbits;

  // clamp of the managed count to the built depth
  assign m = (blocks_in_use > FW'(rffba_pkg::NUM_BLOCKS)) ? FW'(rffba_pkg::NUM_BLOCKS)
                                                          : blocks_in_use;

  assign s_tready  = (state == S_IDLE);
  assign div_start = s_tvalid && s_tready && (s_tuser == rffba_pkg::REQ_ALLOC);

  rffba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[39:8]),
    .divisor  (block_bytes),
    .res      (div_res)
  );

  rffba_ram #(
    .WIDTH (rffba_pkg::ENTRY_W),
    .DEPTH (rffba_pkg::NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = rffba_pkg::entry_t'(ram_rbits);

  // quotient rounded up, at least one block
  logic [rffba_pkg::SIZE_W:0] need_full;
  logic [rffba_pkg::SIZE_W:0] need_min;
  assign need_full = {1'b0, div_res.quot} + (rffba_pkg::SIZE_W+1)'(div_res.rem_nz);
  assign need_min  = (need_full == '0) ? (rffba_pkg::SIZE_W+1)'(1) : need_full;

  // walk position, 1-based
  logic [FW:0] pos;
  logic        pos_ok;
  logic        walk_more;
  assign pos       = {1'b0, rstart} + {1'b0, cnt};
  assign pos_ok    = (pos != '0) && (pos <= {1'b0, m});
  assign walk_more = !err && (cnt != rcount);

  // scan: next run length and hit
  logic          scan_issue;
  logic [FW-1:0] run_new;
  logic          scan_hit;
  assign scan_issue = (state == S_SCAN) && (cnt < m);
  assign run_new    = (ram_rdata.st == rffba_pkg::BLK_FREE) ? run + FW'(1) : '0;
  assign scan_hit   = p_valid && (run_new == need);

  // read-modify-write of one entry for free, share and unshare
  rffba_pkg::entry_t       upd;
  logic [rffba_pkg::REFS_W-1:0] refs_dec;
  assign refs_dec = (ram_rdata.refs != '0) ? ram_rdata.refs - rffba_pkg::REFS_W'(1) : '0;

  always_comb begin
    upd = ram_rdata;
    case (req)
      rffba_pkg::REQ_FREE: begin
        if (ram_rdata.st != rffba_pkg::BLK_FREE) begin
          upd.refs = refs_dec;
          if (refs_dec == '0) begin
            upd.st    = rffba_pkg::BLK_FREE;
            upd.owner = rffba_pkg::NO_OWNER;
          end
        end
      end
      rffba_pkg::REQ_SHARE: begin
        if (agent != rffba_pkg::NO_OWNER && ram_rdata.owner == agent) begin
          upd.st = rffba_pkg::BLK_SHARED;
          if (ram_rdata.refs != rffba_pkg::REFS_MAX) begin
            upd.refs = ram_rdata.refs + rffba_pkg::REFS_W'(1);
          end
        end
      end
      rffba_pkg::REQ_UNSHARE: begin
        if (ram_rdata.refs != '0) begin
          upd.refs = refs_dec;
          if (refs_dec == rffba_pkg::REFS_W'(1)) begin
            upd.st = rffba_pkg::BLK_ALLOC;
          end
        end
      end
      default: begin
        upd = ram_rdata;
      end
    endcase
  end

  // table port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    ram_wdata = upd;
    ram_raddr = cnt[IW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[IW-1:0];
        ram_wdata = '{st: rffba_pkg::BLK_FREE, refs: '0, owner: rffba_pkg::NO_OWNER};
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = start0 + cnt[IW-1:0];
        ram_wdata = '{st: rffba_pkg::BLK_ALLOC, refs: rffba_pkg::REFS_W'(1), owner: agent};
      end
      S_WALK: begin
        ram_we    = p_valid;
        ram_raddr = IW'(pos - (FW+1)'(1));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // used count after an allocate
  logic [FW:0] used_add;
  assign used_add = {1'b0, used} + {1'b0, need};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      p_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
      used          <= '0;
      block_bytes   <= rffba_pkg::BB_W'(4096);
      blocks_in_use <= FW'(1024);
    end else begin
      if (cfg_we) begin
        case (rffba_pkg::cfg_idx_t'(cfg_index))
          rffba_pkg::CFG_BLOCK_BYTES:   block_bytes   <= cfg_data;
          rffba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[FW-1:0];
          default: ;
        endcase
      end
      // a result taken while the next one is ready is replaced in the finish state
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + FW'(1);
          if (cnt == FW'(rffba_pkg::NUM_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req         <= rffba_pkg::req_t'(s_tuser);
            agent       <= s_tdata[7:0];
            rstart      <= s_tdata[50:40];
            rcount      <= s_tdata[61:51];
            cnt         <= '0;
            run         <= '0;
            p_valid     <= 1'b0;
            err         <= 1'b0;
            status      <= rffba_pkg::STAT_OK;
            start_block <= '0;
            granted     <= '0;
            state       <= (s_tuser == rffba_pkg::REQ_ALLOC) ? S_DIV : S_WALK;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            need <= need_min[FW-1:0];
            if (need_min > {{(rffba_pkg::SIZE_W+1-FW){1'b0}}, m}) begin
              status <= rffba_pkg::STAT_NO_SPACE;
              state  <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          p_valid <= scan_issue && !scan_hit;
          p_idx   <= cnt[IW-1:0];
          if (scan_issue) begin
            cnt <= cnt + FW'(1);
          end
          if (p_valid) begin
            run <= run_new;
          end
          if (scan_hit) begin
            start0      <= IW'({1'b0, p_idx} + FW'(1) - need);
            start_block <= FW'({1'b0, p_idx} + FW'(2) - need);
            granted     <= need;
            cnt         <= '0;
            p_valid     <= 1'b0;
            state       <= S_FILL;
          end else if (!p_valid && !scan_issue) begin
            status <= rffba_pkg::STAT_NO_SPACE;
            state  <= S_FINISH;
          end
        end
        S_FILL: begin
          cnt <= cnt + FW'(1);
          if (cnt == need - FW'(1)) begin
            used  <= (used_add > (FW+1)'(rffba_pkg::USED_MAX)) ? FW'(rffba_pkg::USED_MAX)
                                                              : used_add[FW-1:0];
            state <= S_FINISH;
          end
        end
        S_WALK: begin
          p_valid <= 1'b0;
          p_idx   <= IW'(pos - (FW+1)'(1));
          if (walk_more) begin
            if (pos_ok) begin
              p_valid <= 1'b1;
              cnt     <= cnt + FW'(1);
            end else if (req == rffba_pkg::REQ_UNSHARE) begin
              cnt <= cnt + FW'(1);
            end else begin
              err    <= 1'b1;
              status <= rffba_pkg::STAT_RANGE_ERR;
            end
          end else if (!p_valid) begin
            if (req == rffba_pkg::REQ_FREE && !err) begin
              used <= (used > rcount) ? used - rcount : '0;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, used, granted, start_block, status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // table writes after the clearing pass stay inside the managed blocks
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_CLEAR) |-> ({1'b0, ram_waddr} < m))
    else $error("table write beyond managed blocks");

  // no request is taken right after reset
  a_clear_first: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("request taken during clearing pass");

  // the status code is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] <= rffba_pkg::STAT_RANGE_ERR))
    else $error("undefined status code");

  // an error or no-space result grants nothing
  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != rffba_pkg::STAT_OK) |-> (m_tdata[23:2] == '0))
    else $error("blocks granted on a failed request");
`endif

endmodule
